### rtl/msmr_pkg.sv
// msmr_pkg: shared constants, types and codes for the masked axis sum/mean reducer
// no dependencies; imported by msmr_front, msmr_back and the top level
package msmr_pkg;

    // defaults for the top-level size parameters
    localparam int INNER_MAX_DEF = 256;
    localparam int AXIS_MAX_DEF  = 1024;

    // fixed field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int RESULT_W   = 32;
    localparam int POS_W      = 8;
    localparam int PROD_W     = RESULT_W + COEFF_W;
    localparam int IC_W       = 9;
    localparam int AL_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = RESULT_W + POS_W;

    // width used for size compares, covers parameter ranges
    localparam int SZ_W = 17;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    // saturation bounds of the result
    localparam logic signed [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic signed [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_INNER_COUNT = 2'd1,
        CFG_AXIS_LEN    = 2'd2,
        CFG_COEFF       = 2'd3
    } t_cfg_idx;

    // per-item control flags from front to back
    typedef struct packed {
        logic keep;
        logic first;
        logic last_pos;
        logic last_step;
    } t_item_flags;

    localparam int FLAGS_W = $bits(t_item_flags);

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_RD,
        ST_UPD,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

### rtl/msmr_fifo.sv
// msmr_fifo: small register queue that decouples the front from the back
// no package dependencies; generic width and depth
module msmr_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end
endmodule

### rtl/msmr_front.sv
// msmr_front: tracks inner position, axis step and kept-step count per item
// depends on msmr_pkg; feeds the queue toward msmr_back
module msmr_front #(
    parameter int INNER_MAX = msmr_pkg::INNER_MAX_DEF,
    parameter int AXIS_MAX  = msmr_pkg::AXIS_MAX_DEF,
    parameter int IW        = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1,
    parameter int CW        = (AXIS_MAX > 0) ? $clog2(AXIS_MAX + 1) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_keep,
    input  logic [msmr_pkg::IC_W-1:0]   i_inner_count,
    input  logic [msmr_pkg::AL_W-1:0]   i_axis_len,
    output logic [IW-1:0]               o_pos,
    output logic [CW-1:0]               o_kept,
    output msmr_pkg::t_item_flags       o_flags
);
    import msmr_pkg::*;

    localparam int AW = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1;

    logic [IW-1:0]   r_inner_idx;
    logic [AW-1:0]   r_axis_idx;
    logic [CW-1:0]   r_kept;
    logic [IW-1:0]   n_inner_idx;
    logic [AW-1:0]   n_axis_idx;
    logic [CW-1:0]   n_kept;
    logic [SZ_W-1:0] w_n;
    logic [SZ_W-1:0] w_len;
    logic            w_first;
    logic            w_pos0;
    logic            w_last_pos;
    logic            w_last_step;

    // clamp sizes: zero acts as one, oversize acts as the maximum
    always_comb begin
        if (i_inner_count == '0) begin
            w_n = SZ_W'(1);
        end else if (SZ_W'(i_inner_count) > SZ_W'(INNER_MAX)) begin
            w_n = SZ_W'(INNER_MAX);
        end else begin
            w_n = SZ_W'(i_inner_count);
        end
        if (i_axis_len == '0) begin
            w_len = SZ_W'(1);
        end else if (SZ_W'(i_axis_len) > SZ_W'(AXIS_MAX)) begin
            w_len = SZ_W'(AXIS_MAX);
        end else begin
            w_len = SZ_W'(i_axis_len);
        end
    end

    // classify the current item
    always_comb begin
        w_first     = (r_axis_idx == '0);
        w_pos0      = (r_inner_idx == '0);
        w_last_pos  = ((SZ_W'(r_inner_idx) + SZ_W'(1)) >= w_n);
        w_last_step = ((SZ_W'(r_axis_idx) + SZ_W'(1)) >= w_len);

        // kept count follows position 0 only
        if (w_pos0) begin
            n_kept = w_first ? CW'(i_keep) : r_kept + CW'(i_keep);
        end else begin
            n_kept = r_kept;
        end

        if (w_last_pos) begin
            n_inner_idx = '0;
            n_axis_idx  = w_last_step ? '0 : r_axis_idx + AW'(1);
        end else begin
            n_inner_idx = r_inner_idx + IW'(1);
            n_axis_idx  = r_axis_idx;
        end
    end

    assign o_pos             = r_inner_idx;
    assign o_kept            = n_kept;
    assign o_flags.keep      = i_keep;
    assign o_flags.first     = w_first;
    assign o_flags.last_pos  = w_last_pos;
    assign o_flags.last_step = w_last_step;

    // counters advance on every queued item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_idx <= '0;
            r_axis_idx  <= '0;
            r_kept      <= '0;
        end else if (i_push) begin
            r_inner_idx <= n_inner_idx;
            r_axis_idx  <= n_axis_idx;
            r_kept      <= n_kept;
        end
    end
endmodule

### rtl/msmr_div.sv
// msmr_div: restoring unsigned divider, one quotient bit per cycle
// no package dependencies; used by msmr_back for the mean
module msmr_div #(
    parameter int DW = 48,
    parameter int VW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

    logic [DW-1:0]    r_q;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      w_shift;
    logic [VW:0]      w_diff;
    logic             w_ge;

    // one restoring step
    always_comb begin
        w_shift = {r_rem, r_q[DW-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
        end
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

### rtl/msmr_back.sv
// msmr_back: accumulator memory update, scaling, mean division, output register
// depends on msmr_pkg and msmr_div
module msmr_back #(
    parameter int INNER_MAX = msmr_pkg::INNER_MAX_DEF,
    parameter int AXIS_MAX  = msmr_pkg::AXIS_MAX_DEF,
    parameter int IW        = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1,
    parameter int CW        = (AXIS_MAX > 0) ? $clog2(AXIS_MAX + 1) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_pop,
    input  logic signed [msmr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [IW-1:0]                       i_pos,
    input  logic [CW-1:0]                       i_kept,
    input  msmr_pkg::t_item_flags               i_flags,
    input  logic                                i_mode,
    input  logic signed [msmr_pkg::COEFF_W-1:0] i_coeff,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [msmr_pkg::RESULT_W-1:0]       o_result,
    output logic [msmr_pkg::POS_W-1:0]          o_position,
    output logic                                o_last,
    output logic                                o_empty
);
    import msmr_pkg::*;

    t_back_state                r_state;
    t_back_state                n_state;
    logic signed [RESULT_W-1:0] r_mem [INNER_MAX];
    logic signed [RESULT_W-1:0] r_rd;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [IW-1:0]              r_pos;
    logic [CW-1:0]              r_kept;
    t_item_flags                r_flags;
    logic signed [RESULT_W-1:0] r_acc;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_neg;
    logic signed [RESULT_W-1:0] r_res;
    logic                       r_empty;
    logic                       r_out_valid;
    logic [RESULT_W-1:0]        r_out_result;
    logic [POS_W-1:0]           r_out_pos;
    logic                       r_out_last;
    logic                       r_out_empty;

    logic                       w_div_start;
    logic                       w_div_done;
    logic [PROD_W-1:0]          w_quot;
    logic [PROD_W-1:0]          w_dividend;
    logic [CW-1:0]              w_half;
    logic signed [RESULT_W:0]   w_sum;
    logic signed [RESULT_W-1:0] w_sum_sat;
    logic signed [RESULT_W-1:0] w_new_acc;
    logic signed [RESULT_W-1:0] w_plain_res;
    logic signed [RESULT_W-1:0] w_div_res;
    logic [IW+POS_W-1:0]        w_pos_ext;
    logic                       w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    // sequencer next state and handshakes
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_RD: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_state = r_flags.last_step ? ST_MUL : ST_RD;
            end
            ST_MUL: begin
                n_state = ST_PREP;
            end
            ST_PREP: begin
                if (i_mode && (r_kept != '0)) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_RD;
                end
            end
            default: begin
                n_state = ST_RD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RD;
        end else begin
            r_state <= n_state;
        end
    end

    // accumulator update with saturating add
    always_comb begin
        w_sum = (RESULT_W+1)'(r_rd) + (RESULT_W+1)'(r_sample);
        if (w_sum[RESULT_W] != w_sum[RESULT_W-1]) begin
            w_sum_sat = w_sum[RESULT_W] ? RES_MIN : RES_MAX;
        end else begin
            w_sum_sat = w_sum[RESULT_W-1:0];
        end
        if (r_flags.first) begin
            w_new_acc = r_flags.keep ? RESULT_W'(r_sample) : '0;
        end else begin
            w_new_acc = r_flags.keep ? w_sum_sat : r_rd;
        end
    end

    // rounding dividend: magnitude plus half the count, one add
    always_comb begin
        w_half     = r_kept >> 1;
        w_dividend = (r_prod[PROD_W-1] ? ~PROD_W'(r_prod) : PROD_W'(r_prod))
                     + PROD_W'(w_half) + PROD_W'(r_prod[PROD_W-1]);
    end

    // sum-mode saturation and mean sign restore
    always_comb begin
        if (r_prod > PROD_W'(RES_MAX)) begin
            w_plain_res = RES_MAX;
        end else if (r_prod < PROD_W'(RES_MIN)) begin
            w_plain_res = RES_MIN;
        end else begin
            w_plain_res = r_prod[RESULT_W-1:0];
        end
        if (!r_neg) begin
            w_div_res = (w_quot > PROD_W'(RES_MAX)) ? RES_MAX : w_quot[RESULT_W-1:0];
        end else begin
            w_div_res = (w_quot > PROD_W'({1'b1, {(RESULT_W-1){1'b0}}})) ? RES_MIN
                        : -w_quot[RESULT_W-1:0];
        end
    end

    // accumulator memory, registered read at the queue head
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_mem[r_pos] <= w_new_acc;
        end
        r_rd <= r_mem[i_pos];
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= i_sample;
            r_pos    <= i_pos;
            r_kept   <= i_kept;
            r_flags  <= i_flags;
        end
        if (r_state == ST_UPD) begin
            r_acc <= w_new_acc;
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_acc * i_coeff;
        end
        if (r_state == ST_PREP) begin
            r_neg   <= r_prod[PROD_W-1];
            r_empty <= i_mode && (r_kept == '0);
            r_res   <= i_mode ? '0 : w_plain_res;
        end
        if ((r_state == ST_DIV) && w_div_done) begin
            r_res <= w_div_res;
        end
    end

    msmr_div #(
        .DW (PROD_W),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_kept),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_pos_ext = (IW+POS_W)'(r_pos);

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_result <= r_res;
            r_out_pos    <= w_pos_ext[POS_W-1:0];
            r_out_last   <= r_flags.last_pos;
            r_out_empty  <= r_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_result   = r_out_result;
    assign o_position = r_out_pos;
    assign o_last     = r_out_last;
    assign o_empty    = r_out_empty;
endmodule

### rtl/masked_axis_sum_mean_reduce.sv
// masked_axis_sum_mean_reduce: masked sum or mean of a tensor along one axis
// depends on msmr_pkg, msmr_front, msmr_fifo, msmr_back, msmr_div
//
// channel   direction  contents
// s_axis    in         tdata: sample[15:0]; tuser: keep
// m_axis    out        tdata: result[31:0], position[39:32]; tlast: last; tuser: empty_res
// cfg       in         i_cfg_we, i_cfg_idx (mode, inner_count, axis_len, coeff), i_cfg_data
//
// the front takes one item a cycle into a four-entry queue while it has room
// the back does each item's accumulator read-modify-write in its read and update states
// an item on the last axis step also passes through the multiply, prep and output states, and
// in mean mode with a nonzero kept count also through the bit-serial divider
// reset is synchronous active low; accumulators hold no reset value
// a waiting result sits in the output register while the queue keeps filling
module masked_axis_sum_mean_reduce #(
    parameter int INNER_MAX = msmr_pkg::INNER_MAX_DEF,
    parameter int AXIS_MAX  = msmr_pkg::AXIS_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [msmr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msmr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [msmr_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // sample
    input  logic [0:0]                          s_axis_tuser,  // keep
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [msmr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // result, position
    output logic                                m_axis_tlast,  // last
    output logic [0:0]                          m_axis_tuser   // empty_res
);
    import msmr_pkg::*;

    localparam int IW  = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
    localparam int CW  = $clog2(AXIS_MAX + 1);
    localparam int QW  = SAMPLE_W + IW + CW + FLAGS_W;

    logic                       r_mode;
    logic [IC_W-1:0]            r_inner_count;
    logic [AL_W-1:0]            r_axis_len;
    logic signed [COEFF_W-1:0]  r_coeff;

    logic                       w_push;
    logic                       w_full;
    logic [IW-1:0]              w_f_pos;
    logic [CW-1:0]              w_f_kept;
    t_item_flags                w_f_flags;
    logic [QW-1:0]              w_q_in;
    logic [QW-1:0]              w_q_out;
    logic                       w_q_valid;
    logic                       w_q_pop;
    logic [RESULT_W-1:0]        w_result;
    logic [POS_W-1:0]           w_position;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_inner_count <= IC_W'(1);
            r_axis_len    <= AL_W'(1);
            r_coeff       <= COEFF_W'(256);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:        r_mode        <= i_cfg_data[0];
                CFG_INNER_COUNT: r_inner_count <= i_cfg_data[IC_W-1:0];
                CFG_AXIS_LEN:    r_axis_len    <= i_cfg_data[AL_W-1:0];
                CFG_COEFF:       r_coeff       <= i_cfg_data[COEFF_W-1:0];
            endcase
        end
    end

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    // front: position, step and kept count
    msmr_front #(
        .INNER_MAX (INNER_MAX),
        .AXIS_MAX  (AXIS_MAX),
        .IW        (IW),
        .CW        (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_keep        (s_axis_tuser[0]),
        .i_inner_count (r_inner_count),
        .i_axis_len    (r_axis_len),
        .o_pos         (w_f_pos),
        .o_kept        (w_f_kept),
        .o_flags       (w_f_flags)
    );

    assign w_q_in = {s_axis_tdata, w_f_pos, w_f_kept, w_f_flags};

    // queue between front and back
    msmr_fifo #(
        .W     (QW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    // back: accumulate, scale, divide
    msmr_back #(
        .INNER_MAX (INNER_MAX),
        .AXIS_MAX  (AXIS_MAX),
        .IW        (IW),
        .CW        (CW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_pop      (w_q_pop),
        .i_sample   (w_q_out[QW-1 -: SAMPLE_W]),
        .i_pos      (w_q_out[IW+CW+FLAGS_W-1 -: IW]),
        .i_kept     (w_q_out[CW+FLAGS_W-1 -: CW]),
        .i_flags    (t_item_flags'(w_q_out[FLAGS_W-1:0])),
        .i_mode     (r_mode),
        .i_coeff    (r_coeff),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_result),
        .o_position (w_position),
        .o_last     (m_axis_tlast),
        .o_empty    (m_axis_tuser[0])
    );

    assign m_axis_tdata = {w_position, w_result};
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for masked_axis_sum_mean_reduce
// holds a scoreboard class with its own reduction predictor; depends on msmr_pkg and the rtl

module tb;
    import msmr_pkg::*;

    localparam int RAND_ITEMS  = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 120;

    // one reduced output item
    typedef struct {
        logic signed [RESULT_W-1:0] value;
        logic [POS_W-1:0]           pos;
        logic                       last;
        logic                       empty;
    } t_reduce_out;

    // predictor of the reduction plus the queue of expected outputs
    class reduce_scoreboard;
        bit                         mean_mode;
        bit [IC_W-1:0]              inner_reg;
        bit [AL_W-1:0]              axis_reg;
        logic signed [COEFF_W-1:0]  scale;
        logic signed [RESULT_W-1:0] acc_bank [INNER_MAX_DEF];
        int unsigned                inner_idx;
        int unsigned                axis_idx;
        int unsigned                kept_steps;
        t_reduce_out                expected_q [$];
        int                         errors;

        static function int unsigned eff_size(int unsigned v, int unsigned cap);
            if (v == 0) return 1;
            if (v > cap) return cap;
            return v;
        endfunction

        static function longint clip32(longint v);
            if (v > longint'(RES_MAX)) return longint'(RES_MAX);
            if (v < longint'(RES_MIN)) return longint'(RES_MIN);
            return v;
        endfunction

        function void reset_state();
            mean_mode  = 1'b0;
            inner_reg  = IC_W'(1);
            axis_reg   = AL_W'(1);
            scale      = COEFF_W'(256);
            foreach (acc_bank[i]) acc_bank[i] = '0;
            inner_idx  = 0;
            axis_idx   = 0;
            kept_steps = 0;
            errors     = 0;
            expected_q.delete();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:        mean_mode = data[0];
                CFG_INNER_COUNT: inner_reg = data[IC_W-1:0];
                CFG_AXIS_LEN:    axis_reg  = data[AL_W-1:0];
                CFG_COEFF:       scale     = data;
                default: ;
            endcase
        endfunction

        // accepted input item: update accumulators, queue a result on the last axis step
        function void note_input(logic signed [SAMPLE_W-1:0] smp, logic kp);
            int unsigned n;
            int unsigned len;
            int unsigned pos;
            bit          last_pos;
            bit          last_step;
            longint      prod;
            longint      mag;
            t_reduce_out r;
            n         = eff_size(inner_reg, INNER_MAX_DEF);
            len       = eff_size(axis_reg, AXIS_MAX_DEF);
            pos       = (inner_idx >= INNER_MAX_DEF) ? INNER_MAX_DEF - 1 : inner_idx;
            last_pos  = (inner_idx + 1 >= n);
            last_step = (axis_idx + 1 >= len);

            // first axis step loads, later steps add where kept
            if (axis_idx == 0) begin
                acc_bank[pos] = kp ? RESULT_W'(longint'(smp)) : '0;
                if (inner_idx == 0) kept_steps = kp ? 1 : 0;
            end else begin
                if (kp)
                    acc_bank[pos] = RESULT_W'(clip32(longint'(acc_bank[pos]) + longint'(smp)));
                if (inner_idx == 0 && kp) kept_steps++;
            end

            if (last_step) begin
                prod    = longint'(acc_bank[pos]) * longint'(scale);
                r.value = '0;
                r.empty = 1'b0;
                if (!mean_mode) begin
                    r.value = RESULT_W'(clip32(prod));
                end else if (kept_steps == 0) begin
                    r.empty = 1'b1;
                end else begin
                    // round to nearest, ties away from zero
                    mag     = (prod < 0) ? -prod : prod;
                    mag     = (mag + longint'(kept_steps / 2)) / longint'(kept_steps);
                    r.value = RESULT_W'(clip32((prod < 0) ? -mag : mag));
                end
                r.pos  = pos[POS_W-1:0];
                r.last = last_pos;
                expected_q.push_back(r);
            end

            if (last_pos) begin
                inner_idx = 0;
                axis_idx  = last_step ? 0 : axis_idx + 1;
            end else begin
                inner_idx++;
            end
        endfunction

        // accepted output item against the oldest expected one
        function void check_result(logic [RESULT_W-1:0] value, logic [POS_W-1:0] pos,
                                   logic last, logic empty);
            t_reduce_out e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output: value %0d pos %0d last %0b empty %0b",
                             $signed(value), pos, last, empty);
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.value || pos !== e.pos || last !== e.last || empty !== e.empty) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected value %0d pos %0d last %0b empty %0b",
                             e.value, e.pos, e.last, e.empty);
                    $display("          got value %0d pos %0d last %0b empty %0b",
                             $signed(value), pos, last, empty);
                end
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;  // sample
    logic [0:0]            s_axis_tuser  = '0;  // keep
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // result[31:0], position[39:32]
    logic                  m_axis_tlast;        // last
    logic [0:0]            m_axis_tuser;        // empty_res

    int          snd_idle_pct = 23;
    int          rcv_idle_pct = 70;
    bit          hold_req     = 1'b0;
    bit          hold_done    = 1'b0;
    int          hold_left    = 0;
    int          stall_cycles = 0;
    int unsigned cur_n        = 1;
    int unsigned cur_len      = 1;

    reduce_scoreboard sb = new();

    masked_axis_sum_mean_reduce dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // output ready, with random idling and one long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[RESULT_W-1:0],
                                m_axis_tdata[OUT_DATA_W-1:RESULT_W],
                                m_axis_tlast, m_axis_tuser[0]);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL masked_axis_sum_mean_reduce");
                $finish;
            end
        end
    end

    // sample values biased toward the extremes
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // offer one input item, with random idle cycles before it
    task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic kp);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= kp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_one(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // write all four registers back to back
    task automatic apply_setting(input bit md, input int unsigned ic, input int unsigned al,
                                 input int cf);
        write_one(CFG_MODE, CFG_DATA_W'(md));
        write_one(CFG_INNER_COUNT, CFG_DATA_W'(ic));
        write_one(CFG_AXIS_LEN, CFG_DATA_W'(al));
        write_one(CFG_COEFF, CFG_DATA_W'(cf));
        i_cfg_we <= 1'b0;
        cur_n   = reduce_scoreboard::eff_size(ic, INNER_MAX_DEF);
        cur_len = reduce_scoreboard::eff_size(al, AXIS_MAX_DEF);
    endtask

    // stop offering, wait for all expected outputs, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int unsigned rand_items;
        int unsigned phase_no;
        int unsigned ic_v;
        int unsigned al_v;
        int unsigned per_group;
        int unsigned groups;
        int unsigned cut;
        int unsigned total;
        int          cf_v;
        int          keep_pct;
        bit          md_v;
        bit          mixed_keep;
        bit          step_keep;

        sb.reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // load every accumulator once: oversize inner count acts as the widest group
        apply_setting(1'b0, 511, 1, 256);
        for (int k = 0; k < INNER_MAX_DEF; k++)
            send_item(pick_sample(), 1'($urandom_range(1)));
        drain();

        // extreme samples and coeff in sum mode
        apply_setting(1'b0, 2, 2, 32767);
        send_item(16'h7FFF, 1'b1);
        send_item(16'h8000, 1'b1);
        send_item(16'h7FFF, 1'b1);
        send_item(16'h8000, 1'b1);
        drain();

        // mean with most negative coeff, one dropped step
        apply_setting(1'b1, 1, 4, -32768);
        send_item(16'h7FFF, 1'b1);
        send_item(16'h7FFF, 1'b1);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b1);
        drain();

        // empty mean: nothing kept
        apply_setting(1'b1, 3, 2, 256);
        for (int k = 0; k < 6; k++) send_item(pick_sample(), 1'b0);
        drain();

        // rounding ties both signs, keep bits differing within a step
        apply_setting(1'b1, 2, 2, 1);
        send_item(16'h0001, 1'b1);
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0000, 1'b1);
        send_item(16'h0000, 1'b0);
        drain();

        // zero sizes act as one
        apply_setting(1'b0, 0, 0, 256);
        send_item(16'h1234, 1'b1);
        send_item(16'hFEDC, 1'b0);
        drain();

        // oversize axis length acts as the maximum, mean over one position
        apply_setting(1'b1, 1, 2047, 256);
        for (int k = 0; k < AXIS_MAX_DEF; k++)
            send_item(pick_sample(), 1'($urandom_range(1)));
        drain();

        // random phases
        rand_items = 0;
        phase_no   = 0;
        while (rand_items < RAND_ITEMS) begin
            phase_no++;
            if (rand_items < RAND_ITEMS / 3) begin
                snd_idle_pct <= 23;
                rcv_idle_pct <= 70;
            end else if (rand_items < 2 * RAND_ITEMS / 3) begin
                snd_idle_pct <= 70;
                rcv_idle_pct <= 23;
            end else begin
                snd_idle_pct <= 0;
                rcv_idle_pct <= 0;
            end

            md_v = 1'($urandom_range(1));
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: ic_v = $urandom_range(1, 4);
                6, 7:             ic_v = $urandom_range(5, 24);
                8:                ic_v = $urandom_range(25, 64);
                default:          ic_v = 0;
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: al_v = $urandom_range(1, 4);
                6, 7, 8:          al_v = $urandom_range(5, 16);
                default:          al_v = 0;
            endcase
            case ($urandom_range(6))
                0:       cf_v = 256;
                1:       cf_v = 32767;
                2:       cf_v = -32768;
                3:       cf_v = -1;
                4:       cf_v = 0;
                default: cf_v = int'($urandom_range(65535)) - 32768;
            endcase

            // forced settings: pressure, zero sizes
            case (phase_no)
                2: begin
                    md_v = 1'b0;
                    ic_v = 4;
                    al_v = 1;
                    hold_req <= 1'b1;
                end
                5: begin
                    ic_v = 0;
                    al_v = 0;
                end
                default: ;
            endcase

            apply_setting(md_v, ic_v, al_v, cf_v);

            case ($urandom_range(4))
                0:       keep_pct = 0;
                1:       keep_pct = 50;
                2:       keep_pct = 80;
                default: keep_pct = 100;
            endcase
            mixed_keep = ($urandom_range(4) == 0);
            per_group  = cur_n * cur_len;
            groups     = 1 + 48 / per_group;
            // now and then the last group is broken off early
            cut = (per_group > 1 && $urandom_range(7) == 0) ?
                  $urandom_range(1, per_group - 1) : 0;

            step_keep = 1'b1;
            for (int g = 0; g < groups; g++) begin
                total = (g == groups - 1 && cut != 0) ? cut : per_group;
                for (int k = 0; k < total; k++) begin
                    if (mixed_keep || (k % cur_n) == 0)
                        step_keep = ($urandom_range(99) < keep_pct);
                    send_item(pick_sample(), step_keep);
                    rand_items++;
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS masked_axis_sum_mean_reduce");
        end else begin
            $display("FAIL masked_axis_sum_mean_reduce");
        end
        $finish;
    end

endmodule
